[hw/rtl/segment_intersection_test_core_defines.svh]
// assertion macros used by the top rtl file segment_intersection_test_core.sv
`ifndef SEGMENT_INTERSECTION_TEST_CORE_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_CORE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, checked on clk_i, off during reset
`define SIT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i, off during reset
`define SIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SIT_ASSERT_IMP(lbl, ante, cons, msg)
`define SIT_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/sit_pkg.sv]
package sit_pkg;

  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned DiffWidth   = COORD_WIDTH + 1;
  localparam int unsigned ProdWidth   = 2 * DiffWidth;
  localparam int unsigned CrossWidth  = ProdWidth + 1;
  localparam int unsigned NumOrient   = 4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]   diff_t;
  typedef logic signed [ProdWidth-1:0]   prod_t;
  typedef logic signed [CrossWidth-1:0]  cross_t;

  // cross product of one triple is a*b - c*d
  typedef struct packed {
    diff_t a;
    diff_t b;
    diff_t c;
    diff_t d;
  } cross_terms_t;

  typedef enum logic [1:0] {
    ORI_COL,
    ORI_CW,
    ORI_CCW
  } orient_e;

  typedef struct packed {
    logic s2;
    logic s3;
  } cross_en_t;

  typedef struct packed {
    logic s2;
    logic s3;
  } cross_vld_t;

  function automatic diff_t sub_coord(coord_t x, coord_t y);
    diff_t xe;
    diff_t ye;
    xe = $signed({x[COORD_WIDTH-1], x});
    ye = $signed({y[COORD_WIDTH-1], y});
    return xe - ye;
  endfunction

endpackage

[hw/rtl/sit_front.sv]
module sit_front (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            en_i,
  input  logic                                            valid_i,
  input  sit_pkg::coord_t                                 ax_i,
  input  sit_pkg::coord_t                                 ay_i,
  input  sit_pkg::coord_t                                 bx_i,
  input  sit_pkg::coord_t                                 by_i,
  input  sit_pkg::coord_t                                 cx_i,
  input  sit_pkg::coord_t                                 cy_i,
  input  sit_pkg::coord_t                                 dx_i,
  input  sit_pkg::coord_t                                 dy_i,
  output logic                                            valid_o,
  output sit_pkg::cross_terms_t [sit_pkg::NumOrient-1:0]  terms_o,
  output logic [sit_pkg::NumOrient-1:0]                   box_o
);

  logic                                            valid_q;
  sit_pkg::cross_terms_t [sit_pkg::NumOrient-1:0]  terms_d, terms_q;
  logic [sit_pkg::NumOrient-1:0]                   box_d, box_q;

  function automatic logic in_box(sit_pkg::coord_t px, sit_pkg::coord_t py,
                                  sit_pkg::coord_t qx, sit_pkg::coord_t qy,
                                  sit_pkg::coord_t rx, sit_pkg::coord_t ry);
    logic x_ok;
    logic y_ok;
    x_ok = (rx >= px && rx <= qx) || (rx >= qx && rx <= px);
    y_ok = (ry >= py && ry <= qy) || (ry >= qy && ry <= py);
    return x_ok && y_ok;
  endfunction

  always_comb begin
    // (A,B,C)
    terms_d[0].a = sit_pkg::sub_coord(by_i, ay_i);
    terms_d[0].b = sit_pkg::sub_coord(cx_i, bx_i);
    terms_d[0].c = sit_pkg::sub_coord(bx_i, ax_i);
    terms_d[0].d = sit_pkg::sub_coord(cy_i, by_i);
    // (A,B,D)
    terms_d[1].a = sit_pkg::sub_coord(by_i, ay_i);
    terms_d[1].b = sit_pkg::sub_coord(dx_i, bx_i);
    terms_d[1].c = sit_pkg::sub_coord(bx_i, ax_i);
    terms_d[1].d = sit_pkg::sub_coord(dy_i, by_i);
    // (C,D,A)
    terms_d[2].a = sit_pkg::sub_coord(dy_i, cy_i);
    terms_d[2].b = sit_pkg::sub_coord(ax_i, dx_i);
    terms_d[2].c = sit_pkg::sub_coord(dx_i, cx_i);
    terms_d[2].d = sit_pkg::sub_coord(ay_i, dy_i);
    // (C,D,B)
    terms_d[3].a = sit_pkg::sub_coord(dy_i, cy_i);
    terms_d[3].b = sit_pkg::sub_coord(bx_i, dx_i);
    terms_d[3].c = sit_pkg::sub_coord(dx_i, cx_i);
    terms_d[3].d = sit_pkg::sub_coord(by_i, dy_i);

    box_d[0] = in_box(ax_i, ay_i, bx_i, by_i, cx_i, cy_i);
    box_d[1] = in_box(ax_i, ay_i, bx_i, by_i, dx_i, dy_i);
    box_d[2] = in_box(cx_i, cy_i, dx_i, dy_i, ax_i, ay_i);
    box_d[3] = in_box(cx_i, cy_i, dx_i, dy_i, bx_i, by_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      terms_q <= terms_d;
      box_q   <= box_d;
    end
  end

  assign valid_o = valid_q;
  assign terms_o = terms_q;
  assign box_o   = box_q;

endmodule

[hw/rtl/sit_cross.sv]
module sit_cross (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  sit_pkg::cross_en_t                              en_i,
  input  logic                                            valid_i,
  input  sit_pkg::cross_terms_t [sit_pkg::NumOrient-1:0]  terms_i,
  input  logic [sit_pkg::NumOrient-1:0]                   box_i,
  output sit_pkg::cross_vld_t                             vld_o,
  output sit_pkg::orient_e [sit_pkg::NumOrient-1:0]       ori_o,
  output logic [sit_pkg::NumOrient-1:0]                   box_o
);

  sit_pkg::cross_vld_t                          vld_q;
  sit_pkg::prod_t [sit_pkg::NumOrient-1:0]      p_d, p_q;
  sit_pkg::prod_t [sit_pkg::NumOrient-1:0]      q_d, q_q;
  logic [sit_pkg::NumOrient-1:0]                box2_q, box3_q;
  sit_pkg::orient_e [sit_pkg::NumOrient-1:0]    ori_d, ori_q;
  sit_pkg::cross_t [sit_pkg::NumOrient-1:0]     cross_val;

  // stage 2: the two products of each triple
  always_comb begin
    for (int i = 0; i < sit_pkg::NumOrient; i++) begin
      p_d[i] = sit_pkg::ProdWidth'($signed(terms_i[i].a))
             * sit_pkg::ProdWidth'($signed(terms_i[i].b));
      q_d[i] = sit_pkg::ProdWidth'($signed(terms_i[i].c))
             * sit_pkg::ProdWidth'($signed(terms_i[i].d));
    end
  end

  // stage 3: exact sign of the cross product
  always_comb begin
    for (int i = 0; i < sit_pkg::NumOrient; i++) begin
      cross_val[i] = sit_pkg::CrossWidth'($signed(p_q[i]))
                   - sit_pkg::CrossWidth'($signed(q_q[i]));
      if (cross_val[i] == '0) begin
        ori_d[i] = sit_pkg::ORI_COL;
      end else if (cross_val[i][sit_pkg::CrossWidth-1]) begin
        ori_d[i] = sit_pkg::ORI_CCW;
      end else begin
        ori_d[i] = sit_pkg::ORI_CW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en_i.s2) begin
        vld_q.s2 <= valid_i;
      end
      if (en_i.s3) begin
        vld_q.s3 <= vld_q.s2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2 && valid_i) begin
      p_q    <= p_d;
      q_q    <= q_d;
      box2_q <= box_i;
    end
    if (en_i.s3 && vld_q.s2) begin
      ori_q  <= ori_d;
      box3_q <= box2_q;
    end
  end

  assign vld_o = vld_q;
  assign ori_o = ori_q;
  assign box_o = box3_q;

endmodule

[hw/rtl/segment_intersection_test_core.sv]
// throughput: one segment pair per cycle while the output is not stalled, a bubble in any stage is filled on a stall
// stages: differences and box tests, products, cross-product sign, decision
// the rate is set by the four-stage pipeline with one 17x17 multiplier pair per triple
// reset: rst_ni clears all stage valid bits asynchronously, the data registers are not reset
`include "segment_intersection_test_core_defines.svh"

module segment_intersection_test_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  sit_pkg::coord_t ax_i,
  input  sit_pkg::coord_t ay_i,
  input  sit_pkg::coord_t bx_i,
  input  sit_pkg::coord_t by_i,
  input  sit_pkg::coord_t cx_i,
  input  sit_pkg::coord_t cy_i,
  input  sit_pkg::coord_t dx_i,
  input  sit_pkg::coord_t dy_i,
  output logic            valid_o,
  input  logic            stall_i,
  output logic            intersects_o
);

  logic                                            en1, en4;
  sit_pkg::cross_en_t                              cross_en;
  logic                                            front_valid;
  sit_pkg::cross_terms_t [sit_pkg::NumOrient-1:0]  front_terms;
  logic [sit_pkg::NumOrient-1:0]                   front_box;
  sit_pkg::cross_vld_t                             cross_vld;
  sit_pkg::orient_e [sit_pkg::NumOrient-1:0]       ori;
  logic [sit_pkg::NumOrient-1:0]                   ori_box;
  logic                                            valid_q;
  logic                                            hit_d, hit_q;

  // a stage moves when it is empty or the stage after it moves
  assign en4         = !valid_q || !stall_i;
  assign cross_en.s3 = !cross_vld.s3 || en4;
  assign cross_en.s2 = !cross_vld.s2 || cross_en.s3;
  assign en1         = !front_valid || cross_en.s2;
  assign stall_o     = !en1;

  sit_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .valid_i (valid_i),
    .ax_i    (ax_i),
    .ay_i    (ay_i),
    .bx_i    (bx_i),
    .by_i    (by_i),
    .cx_i    (cx_i),
    .cy_i    (cy_i),
    .dx_i    (dx_i),
    .dy_i    (dy_i),
    .valid_o (front_valid),
    .terms_o (front_terms),
    .box_o   (front_box)
  );

  sit_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (cross_en),
    .valid_i (front_valid),
    .terms_i (front_terms),
    .box_i   (front_box),
    .vld_o   (cross_vld),
    .ori_o   (ori),
    .box_o   (ori_box)
  );

  // general crossing, else a collinear endpoint inside the other bounding box
  always_comb begin
    hit_d = (ori[0] != ori[1]) && (ori[2] != ori[3]);
    for (int i = 0; i < sit_pkg::NumOrient; i++) begin
      if (ori[i] == sit_pkg::ORI_COL && ori_box[i]) begin
        hit_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en4) begin
      valid_q <= cross_vld.s3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && cross_vld.s3) begin
      hit_q <= hit_d;
    end
  end

  assign valid_o      = valid_q;
  assign intersects_o = hit_q;

  `SIT_ASSERT_IMP(a_stall_full, stall_o, front_valid && cross_vld.s2 && cross_vld.s3 && valid_q && stall_i, "input stalled with a free stage")
  `SIT_ASSERT_NXT(a_in_lands, valid_i && !stall_o, front_valid, "input transfer did not reach first stage")
  `SIT_ASSERT_NXT(a_out_lands, cross_vld.s3 && en4, valid_o, "last stage item did not reach the output")
  `SIT_ASSERT_NXT(a_out_hold, valid_q && stall_i, valid_o && $stable(hit_q), "stalled result changed")

endmodule

[bench/segment_intersection_test_core_test.sv]
`timescale 1ns / 100ps

module segment_intersection_test_core_test;

  localparam int PIPE_DEPTH  = 4;
  localparam int CYCLE_LIMIT = 800000;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    sit_pkg::coord_t ax;
    sit_pkg::coord_t ay;
    sit_pkg::coord_t bx;
    sit_pkg::coord_t by;
    sit_pkg::coord_t cx;
    sit_pkg::coord_t cy;
    sit_pkg::coord_t dx;
    sit_pkg::coord_t dy;
  } seg_pair_t;

  typedef struct {
    seg_pair_t pair;
    logic      hit;
  } hit_entry_t;

  logic            clk_i;
  logic            rst_ni;
  logic            valid_i;
  logic            stall_o;
  sit_pkg::coord_t ax_i;
  sit_pkg::coord_t ay_i;
  sit_pkg::coord_t bx_i;
  sit_pkg::coord_t by_i;
  sit_pkg::coord_t cx_i;
  sit_pkg::coord_t cy_i;
  sit_pkg::coord_t dx_i;
  sit_pkg::coord_t dy_i;
  logic            valid_o;
  logic            stall_i;
  logic            intersects_o;

  hit_entry_t pending_hits[$];
  int         mismatch_count;
  int         cycle_count;
  bit         sender_eager;
  bit         sink_eager;

  segment_intersection_test_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .ax_i         (ax_i),
    .ay_i         (ay_i),
    .bx_i         (bx_i),
    .by_i         (by_i),
    .cx_i         (cx_i),
    .cy_i         (cy_i),
    .dx_i         (dx_i),
    .dy_i         (dy_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .intersects_o (intersects_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // exact sign of (qy-py)*(rx-qx) - (qx-px)*(ry-qy), fits easily in 64 bits
  function automatic sit_pkg::orient_e turn_of(input longint px, py, qx, qy, rx, ry);
    longint turn;
    turn = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    if (turn > 0) return sit_pkg::ORI_CW;
    if (turn < 0) return sit_pkg::ORI_CCW;
    return sit_pkg::ORI_COL;
  endfunction

  function automatic bit in_span_box(input longint px, py, qx, qy, rx, ry);
    return rx >= ((px < qx) ? px : qx) && rx <= ((px < qx) ? qx : px) &&
           ry >= ((py < qy) ? py : qy) && ry <= ((py < qy) ? qy : py);
  endfunction

  function automatic logic predict_hit(input seg_pair_t s);
    sit_pkg::orient_e o_abc;
    sit_pkg::orient_e o_abd;
    sit_pkg::orient_e o_cda;
    sit_pkg::orient_e o_cdb;
    o_abc = turn_of(s.ax, s.ay, s.bx, s.by, s.cx, s.cy);
    o_abd = turn_of(s.ax, s.ay, s.bx, s.by, s.dx, s.dy);
    o_cda = turn_of(s.cx, s.cy, s.dx, s.dy, s.ax, s.ay);
    o_cdb = turn_of(s.cx, s.cy, s.dx, s.dy, s.bx, s.by);
    if (o_abc != o_abd && o_cda != o_cdb) return 1'b1;
    // collinear endpoint falls back to the bounding box
    return (o_abc == sit_pkg::ORI_COL &&
            in_span_box(s.ax, s.ay, s.bx, s.by, s.cx, s.cy)) ||
           (o_abd == sit_pkg::ORI_COL &&
            in_span_box(s.ax, s.ay, s.bx, s.by, s.dx, s.dy)) ||
           (o_cda == sit_pkg::ORI_COL &&
            in_span_box(s.cx, s.cy, s.dx, s.dy, s.ax, s.ay)) ||
           (o_cdb == sit_pkg::ORI_COL &&
            in_span_box(s.cx, s.cy, s.dx, s.dy, s.bx, s.by));
  endfunction

  function automatic seg_pair_t make_pair(input int ax, ay, bx, by, cx, cy, dx, dy);
    seg_pair_t p;
    p.ax = sit_pkg::coord_t'(ax);
    p.ay = sit_pkg::coord_t'(ay);
    p.bx = sit_pkg::coord_t'(bx);
    p.by = sit_pkg::coord_t'(by);
    p.cx = sit_pkg::coord_t'(cx);
    p.cy = sit_pkg::coord_t'(cy);
    p.dx = sit_pkg::coord_t'(dx);
    p.dy = sit_pkg::coord_t'(dy);
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_eager || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // entered and left at a falling edge
  task automatic send_pair(input seg_pair_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    ax_i    <= p.ax;
    ay_i    <= p.ay;
    bx_i    <= p.bx;
    by_i    <= p.by;
    cx_i    <= p.cx;
    cy_i    <= p.cy;
    dx_i    <= p.dx;
    dy_i    <= p.dy;
    valid_i <= 1'b1;
    do @(posedge clk_i); while (stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // input transfers are predicted before output transfers are checked
  always @(posedge clk_i) begin
    hit_entry_t want;
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        want.pair = '{ax_i, ay_i, bx_i, by_i, cx_i, cy_i, dx_i, dy_i};
        want.hit  = predict_hit(want.pair);
        pending_hits.push_back(want);
      end
      if (valid_o && !stall_i) begin
        if (pending_hits.size() == 0) begin
          report_mismatch("result transfer with nothing pending");
        end else begin
          want = pending_hits.pop_front();
          if (intersects_o !== want.hit) begin
            report_mismatch($sformatf(
              "intersects %b, expected %b for A(%0d,%0d) B(%0d,%0d) C(%0d,%0d) D(%0d,%0d)",
              intersects_o, want.hit, want.pair.ax, want.pair.ay, want.pair.bx,
              want.pair.by, want.pair.cx, want.pair.cy, want.pair.dx, want.pair.dy));
          end
        end
      end
    end
  end

  initial begin
    int r;
    stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      r = $urandom_range(0, 99);
      if (sink_eager || r < 60) begin
        stall_i <= 1'b0;
      end else begin
        stall_i <= 1'b1;
        if (r >= 94) repeat ($urandom_range(8, 30)) @(negedge clk_i);
        else repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end
    end
  end

  task automatic test_directed();
    sender_eager = 1'b0;
    sink_eager   = 1'b0;
    send_pair(make_pair(-10, 0, 10, 0, 0, -10, 0, 10));
    send_pair(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
    send_pair(make_pair(0, 0, 10, 0, 5, 0, 5, 7));
    send_pair(make_pair(0, 0, 10, 10, 10, 10, 20, 0));
    send_pair(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
    send_pair(make_pair(0, 0, 4, 0, 6, 0, 9, 0));
    send_pair(make_pair(0, 0, 4, 4, 4, 4, 9, 9));
    send_pair(make_pair(3, -5, 3, 5, 3, -1, 3, 2));
    send_pair(make_pair(0, 0, 2, 2, 10, 0, 0, 10));
    // single-point segments
    send_pair(make_pair(0, 0, 8, 8, 4, 4, 4, 4));
    send_pair(make_pair(0, 0, 8, 8, 9, 9, 9, 9));
    send_pair(make_pair(0, 0, 8, 8, 4, 5, 4, 5));
    send_pair(make_pair(7, -3, 7, -3, 7, -3, 7, -3));
    send_pair(make_pair(7, -3, 7, -3, 7, -2, 7, -2));
    // full-range coordinates, largest products
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, -32767, 32766, 32767));
    send_pair(make_pair(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32767));
    send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(make_pair(-32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767));
    send_pair(make_pair(-32768, 32767, 32767, 32767, 0, 32767, 32767, 32767));
    send_pair(make_pair(-32768, -32768, 32766, 32766, 0, 0, 100, -50));
    send_pair(make_pair(32767, -32768, -32768, 32767, -1, 0, 0, -1));
    wait_results_drained();
  endtask

  task automatic test_full_range();
    seg_pair_t p;
    sender_eager = 1'b0;
    sink_eager   = 1'b0;
    for (int i = 0; i < 300; i++) begin
      p = seg_pair_t'({$urandom(), $urandom(), $urandom(), $urandom()});
      send_pair(p);
      if (i % 100 == 99) wait_results_drained();
    end
  endtask

  // small clusters give many touching and collinear pairs
  task automatic test_clustered();
    int ox;
    int oy;
    int v[8];
    for (int i = 0; i < 300; i++) begin
      sender_eager = (i % 120) < 30;
      ox = int'($urandom_range(0, 60000)) - 30000;
      oy = int'($urandom_range(0, 60000)) - 30000;
      for (int k = 0; k < 8; k++) v[k] = int'($urandom_range(0, 8)) - 4;
      send_pair(make_pair(ox + v[0], oy + v[1], ox + v[2], oy + v[3],
                          ox + v[4], oy + v[5], ox + v[6], oy + v[7]));
    end
    sender_eager = 1'b0;
    wait_results_drained();
  endtask

  // all four points on one line, sometimes one nudged off by a unit
  task automatic test_collinear();
    int px;
    int py;
    int ux;
    int uy;
    int k[4];
    int nudge;
    sink_eager = 1'b0;
    for (int i = 0; i < 300; i++) begin
      px = int'($urandom_range(0, 60000)) - 30000;
      py = int'($urandom_range(0, 60000)) - 30000;
      ux = int'($urandom_range(0, 8)) - 4;
      uy = int'($urandom_range(0, 8)) - 4;
      for (int j = 0; j < 4; j++) k[j] = int'($urandom_range(0, 120)) - 60;
      nudge = ($urandom_range(0, 3) == 0) ? 1 : 0;
      send_pair(make_pair(px + k[0] * ux, py + k[0] * uy, px + k[1] * ux, py + k[1] * uy,
                          px + k[2] * ux + nudge, py + k[2] * uy,
                          px + k[3] * ux, py + k[3] * uy));
    end
    wait_results_drained();
  endtask

  task automatic test_corner_values();
    int corner_vals[8];
    int v[8];
    corner_vals = '{-32768, -32767, -1, 0, 1, 2, 32766, 32767};
    for (int i = 0; i < 150; i++) begin
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(0, 3) == 0) v[k] = int'($urandom_range(0, 65535)) - 32768;
        else v[k] = corner_vals[$urandom_range(0, 7)];
      end
      send_pair(make_pair(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]));
    end
    wait_results_drained();
  endtask

  // one transfer per cycle on both sides
  task automatic test_back_to_back();
    seg_pair_t p;
    int ox;
    sender_eager = 1'b1;
    sink_eager   = 1'b1;
    for (int i = 0; i < 150; i++) begin
      if (i % 2 == 0) begin
        p = seg_pair_t'({$urandom(), $urandom(), $urandom(), $urandom()});
      end else begin
        ox = int'($urandom_range(0, 20)) - 10;
        p = make_pair(ox, 0, ox + 6, 6, int'($urandom_range(0, 12)) - 3, 3,
                      int'($urandom_range(0, 12)) - 3, int'($urandom_range(0, 8)) - 1);
      end
      send_pair(p);
    end
    sender_eager = 1'b0;
    sink_eager   = 1'b0;
    wait_results_drained();
  endtask

  initial begin
    rst_ni         = 1'b0;
    valid_i        = 1'b0;
    ax_i           = '0;
    ay_i           = '0;
    bx_i           = '0;
    by_i           = '0;
    cx_i           = '0;
    cy_i           = '0;
    dx_i           = '0;
    dy_i           = '0;
    sender_eager   = 1'b0;
    sink_eager     = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_full_range();
    test_clustered();
    test_collinear();
    test_corner_values();
    test_back_to_back();
    wait_results_drained();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/sit_pkg.sv
hw/rtl/sit_front.sv
hw/rtl/sit_cross.sv
hw/rtl/segment_intersection_test_core.sv
bench/segment_intersection_test_core_test.sv
